/* src/ehp_pkg.sv */
// ----------------------------------------------------------------------------
// ehp_pkg
// Shared types and constants for the Ethernet/IPv4/L4 header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ehp_pkg;

  localparam int unsigned HTTP_SCAN_LIMIT_DEF = 4096;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = 2;

  localparam logic [15:0] POS_SATURATED = 16'hFFFF;
  localparam logic [15:0] ETH_HDR_LEN   = 16'd14;
  localparam logic [15:0] MIN_IP_FRAME  = 16'd34;
  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [3:0]  IP_VERSION_4  = 4'd4;
  localparam logic [5:0]  MIN_HDR_LEN   = 6'd20;
  localparam logic [7:0]  PROTO_TCP     = 8'd6;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;
  localparam logic [15:0] TCP_MIN_LEN   = 16'd20;
  localparam logic [15:0] UDP_MIN_LEN   = 16'd8;
  localparam logic [15:0] HTTP_MIN_LEN  = 16'd16;

  typedef enum logic [1:0] {
    L4_NONE  = 2'd0,
    L4_TCP   = 2'd1,
    L4_UDP   = 2'd2,
    L4_OTHER = 2'd3
  } l4_kind_t;

  typedef struct packed {
    logic [7:0]  frame_byte;
    logic        last_byte;
    logic [15:0] wire_len;
    logic [15:0] pos;
    logic        active;
    logic [15:0] cap_len;
  } q_entry_t;

  typedef struct packed {
    logic [15:0] ether_kind;
    logic [7:0]  version_hlen;
    logic [15:0] total_length;
    logic [7:0]  hop_limit;
    logic [7:0]  protocol_number;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [7:0]  tcp_offset_byte;
    logic [2:0]  matched_method;
    logic        line_end_found;
    logic        line_ok;
  } parse_state_t;

  typedef struct packed {
    parse_state_t hdr;
    logic [15:0]  cap_len;
    logic [15:0]  wire_len;
  } snap_t;

endpackage

`default_nettype wire

/* src/ehp_byte_if.sv */
// ----------------------------------------------------------------------------
// ehp_byte_if
// Frame byte channel: one captured byte per item with last mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface ehp_byte_if;
  logic        valid;
  logic        ready;
  logic [7:0]  frame_byte;
  logic        last_byte;
  logic [15:0] wire_len;

  modport source (output valid, frame_byte, last_byte, wire_len, input ready);
  modport sink   (input valid, frame_byte, last_byte, wire_len, output ready);
endinterface

`default_nettype wire

/* src/ehp_rec_if.sv */
// ----------------------------------------------------------------------------
// ehp_rec_if
// Parse record channel: one item per frame.
// ----------------------------------------------------------------------------
`default_nettype none

interface ehp_rec_if;
  logic        valid;
  logic        ready;
  logic        parsed;
  logic [1:0]  l4_kind;
  logic [15:0] ip_len;
  logic [7:0]  ip_ttl;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [15:0] l4_sport;
  logic [15:0] l4_dport;
  logic [2:0]  req_method;
  logic [15:0] cap_len;
  logic [15:0] frame_wire_len;

  modport source (
    output valid, parsed, l4_kind, ip_len, ip_ttl, src_addr, dst_addr,
           l4_sport, l4_dport, req_method, cap_len, frame_wire_len,
    input  ready
  );
  modport sink (
    input  valid, parsed, l4_kind, ip_len, ip_ttl, src_addr, dst_addr,
           l4_sport, l4_dport, req_method, cap_len, frame_wire_len,
    output ready
  );
endinterface

`default_nettype wire

/* src/ehp_front.sv */
// ----------------------------------------------------------------------------
// ehp_front
// Accepts frame bytes, tags each with its position, saturation state and
// running capture length, and pushes it into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ehp_front (
  input  logic              clk,
  input  logic              rst,
  ehp_byte_if.sink          in_ch,
  output logic              push,
  output ehp_pkg::q_entry_t push_data,
  input  logic              full
);
  import ehp_pkg::*;

  logic [15:0] byte_count;
  logic [15:0] byte_count_next;
  logic        active;

  assign in_ch.ready = !full;
  assign push        = in_ch.valid && !full;
  assign active      = (byte_count != POS_SATURATED);

  always_comb begin
    push_data.frame_byte = in_ch.frame_byte;
    push_data.last_byte  = in_ch.last_byte;
    push_data.wire_len   = in_ch.wire_len;
    push_data.pos        = byte_count;
    push_data.active     = active;
    push_data.cap_len    = active ? byte_count + 16'd1 : byte_count;
  end

  always_comb begin
    byte_count_next = byte_count;
    if (push) begin
      if (in_ch.last_byte) begin
        byte_count_next = '0;
      end else if (active) begin
        byte_count_next = byte_count + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else begin
      byte_count <= byte_count_next;
    end
  end

endmodule

`default_nettype wire

/* src/ehp_fifo.sv */
// ----------------------------------------------------------------------------
// ehp_fifo
// Short show-ahead queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module ehp_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ehp_pkg::q_entry_t wr_data,
  output logic              full,
  input  logic              pop,
  output ehp_pkg::q_entry_t rd_data,
  output logic              not_empty
);
  import ehp_pkg::*;

  q_entry_t            mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full      = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign rd_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      if (push && !pop) begin
        count <= count + (QUEUE_AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QUEUE_AW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* src/ehp_back.sv */
// ----------------------------------------------------------------------------
// ehp_back
// Consumes tagged bytes: captures header fields, L4 ports and data offset,
// and scans the TCP payload for an HTTP request line.
// ----------------------------------------------------------------------------
`default_nettype none

module ehp_back #(
  parameter int unsigned HTTP_SCAN_LIMIT = ehp_pkg::HTTP_SCAN_LIMIT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  ehp_pkg::q_entry_t q_head,
  output logic              pop,
  output logic              snap_valid,
  output ehp_pkg::snap_t    snap_data,
  input  logic              snap_ready
);
  import ehp_pkg::*;

  localparam logic [15:0] SCAN_LIM = 16'(HTTP_SCAN_LIMIT);

  localparam logic [63:0] METHOD_TEXT [7] = '{
    "GET     ", "POST    ", "HEAD    ", "PUT     ",
    "DELETE  ", "OPTIONS ", "PATCH   "
  };
  localparam logic [3:0] METHOD_LEN [7] = '{
    4'd4, 4'd5, 4'd5, 4'd4, 4'd7, 4'd8, 4'd6
  };

  parse_state_t hs;
  parse_state_t hf;
  parse_state_t hn;
  parse_state_t hs_next;
  logic [6:0]   cand;
  logic [6:0]   cand_next;
  logic [1:0]   space_count;
  logic [1:0]   space_count_next;
  logic         prev_cr;
  logic         prev_cr_next;

  logic [15:0] pos;
  logic [7:0]  b;
  logic [5:0]  ihl6;
  logic [6:0]  l4s;
  logic        hdr_ok;
  logic        in_l4;
  logic [15:0] r;
  logic [5:0]  doff;
  logic [15:0] idx;
  logic [2:0]  idx3;
  logic        scan_en;
  logic [7:0]  ch;

  assign pos = q_head.pos;
  assign b   = q_head.frame_byte;

  assign pop        = q_valid && (!q_head.last_byte || snap_ready);
  assign snap_valid = q_valid && q_head.last_byte;
  assign snap_data  = '{hdr: hs_next, cap_len: q_head.cap_len, wire_len: q_head.wire_len};

  // fixed header positions
  always_comb begin
    hf = hs;
    if (q_head.active) begin
      if (pos == 16'd12 || pos == 16'd13) hf.ether_kind = {hs.ether_kind[7:0], b};
      if (pos == 16'd14) hf.version_hlen = b;
      if (pos == 16'd16 || pos == 16'd17) hf.total_length = {hs.total_length[7:0], b};
      if (pos == 16'd22) hf.hop_limit = b;
      if (pos == 16'd23) hf.protocol_number = b;
      if (pos >= 16'd26 && pos < 16'd30) hf.source_address = {hs.source_address[23:0], b};
      if (pos >= 16'd30 && pos < 16'd34) hf.dest_address = {hs.dest_address[23:0], b};
    end
  end

  assign ihl6   = {hf.version_hlen[3:0], 2'b00};
  assign l4s    = 7'd14 + {1'b0, ihl6};
  assign hdr_ok = q_head.active && (pos > ETH_HDR_LEN) && (ihl6 >= MIN_HDR_LEN);
  assign in_l4  = hdr_ok && (pos >= {9'd0, l4s});
  assign r      = pos - {9'd0, l4s};

  // L4 header positions
  always_comb begin
    hn = hf;
    if (in_l4) begin
      if (r < 16'd2) begin
        hn.source_port = {hf.source_port[7:0], b};
      end else if (r < 16'd4) begin
        hn.dest_port = {hf.dest_port[7:0], b};
      end else if (r == 16'd12) begin
        hn.tcp_offset_byte = b;
      end
    end
  end

  assign doff    = {hn.tcp_offset_byte[7:4], 2'b00};
  assign idx     = r - {10'd0, doff};
  assign idx3    = idx[2:0];
  assign scan_en = in_l4 && (doff >= MIN_HDR_LEN) && (hn.protocol_number == PROTO_TCP) &&
                   (r >= {10'd0, doff}) && (idx < SCAN_LIM);

  // payload scan
  always_comb begin
    hs_next          = hn;
    cand_next        = cand;
    space_count_next = space_count;
    prev_cr_next     = prev_cr;
    ch               = '0;
    if (scan_en) begin
      if (idx[15:3] == '0) begin
        for (int m = 0; m < 7; m++) begin
          ch = METHOD_TEXT[m][{3'd7 - idx3, 3'b000} +: 8];
          if ({1'b0, idx3} < METHOD_LEN[m]) begin
            if (b != ch) begin
              cand_next[m] = 1'b0;
            end else if ({1'b0, idx3} + 4'd1 == METHOD_LEN[m] && cand[m]) begin
              hs_next.matched_method = 3'(m + 1);
            end
          end
        end
      end
      if (!hn.line_end_found) begin
        if (b == 8'h0A && prev_cr) begin
          hs_next.line_end_found = 1'b1;
          hs_next.line_ok        = (space_count == 2'd2);
        end else if (b == 8'h20 && space_count < 2'd2) begin
          space_count_next = space_count + 2'd1;
        end
        prev_cr_next = (b == 8'h0D);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hs          <= '0;
      cand        <= '1;
      space_count <= '0;
      prev_cr     <= 1'b0;
    end else if (pop) begin
      if (q_head.last_byte) begin
        hs          <= '0;
        cand        <= '1;
        space_count <= '0;
        prev_cr     <= 1'b0;
      end else begin
        hs          <= hs_next;
        cand        <= cand_next;
        space_count <= space_count_next;
        prev_cr     <= prev_cr_next;
      end
    end
  end

endmodule

`default_nettype wire

/* src/ehp_record.sv */
// ----------------------------------------------------------------------------
// ehp_record
// Holds the end-of-frame snapshot and forms the validated parse record.
// ----------------------------------------------------------------------------
`default_nettype none

module ehp_record (
  input  logic           clk,
  input  logic           rst,
  input  logic           snap_valid,
  input  ehp_pkg::snap_t snap_data,
  output logic           snap_ready,
  ehp_rec_if.source      out_ch
);
  import ehp_pkg::*;

  logic        rec_valid;
  snap_t       sr;
  logic [15:0] cl;
  logic [5:0]  ihl6;
  logic [6:0]  l4s;
  logic [5:0]  doff;
  logic [15:0] l4_bytes;
  logic        reject;
  l4_kind_t    kind;

  assign snap_ready   = !rec_valid || out_ch.ready;
  assign out_ch.valid = rec_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (snap_ready) begin
      rec_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_valid && snap_ready) begin
      sr <= snap_data;
    end
  end

  assign cl       = sr.cap_len;
  assign ihl6     = {sr.hdr.version_hlen[3:0], 2'b00};
  assign l4s      = 7'd14 + {1'b0, ihl6};
  assign doff     = {sr.hdr.tcp_offset_byte[7:4], 2'b00};
  assign l4_bytes = cl - {9'd0, l4s};
  assign reject   = (cl < MIN_IP_FRAME) || (sr.hdr.ether_kind != ETH_TYPE_IPV4) ||
                    (sr.hdr.version_hlen[7:4] != IP_VERSION_4) ||
                    (ihl6 < MIN_HDR_LEN) || (cl < {9'd0, l4s});

  always_comb begin
    out_ch.parsed         = 1'b0;
    out_ch.l4_kind        = L4_NONE;
    out_ch.ip_len         = '0;
    out_ch.ip_ttl         = '0;
    out_ch.src_addr       = '0;
    out_ch.dst_addr       = '0;
    out_ch.l4_sport       = '0;
    out_ch.l4_dport       = '0;
    out_ch.req_method     = '0;
    out_ch.cap_len        = '0;
    out_ch.frame_wire_len = '0;
    kind                  = L4_NONE;
    if (!reject) begin
      out_ch.parsed         = 1'b1;
      out_ch.ip_len         = sr.hdr.total_length;
      out_ch.ip_ttl         = sr.hdr.hop_limit;
      out_ch.src_addr       = sr.hdr.source_address;
      out_ch.dst_addr       = sr.hdr.dest_address;
      out_ch.cap_len        = cl;
      out_ch.frame_wire_len = sr.wire_len;
      if (sr.hdr.protocol_number == PROTO_TCP) begin
        if (l4_bytes >= TCP_MIN_LEN) begin
          kind = L4_TCP;
          if (doff >= MIN_HDR_LEN && l4_bytes >= {10'd0, doff} + HTTP_MIN_LEN &&
              sr.hdr.matched_method != '0 && sr.hdr.line_end_found && sr.hdr.line_ok) begin
            out_ch.req_method = sr.hdr.matched_method;
          end
        end
      end else if (sr.hdr.protocol_number == PROTO_UDP) begin
        if (l4_bytes >= UDP_MIN_LEN) begin
          kind = L4_UDP;
        end
      end else begin
        kind = L4_OTHER;
      end
      if (kind == L4_TCP || kind == L4_UDP) begin
        out_ch.l4_sport = sr.hdr.source_port;
        out_ch.l4_dport = sr.hdr.dest_port;
      end
      out_ch.l4_kind = kind;
    end
  end

endmodule

`default_nettype wire

/* src/eth_ipv4_l4_header_parser.sv */
// Throughput: one frame byte per cycle unless the queue is full or a
//   record waits, set by the single-byte update path in the back part.
// Record path: the last byte is queued, then the record is registered
//   from the queue head once the record output is free.
// Reset: synchronous; clears the byte counter, queue, parse state and the
//   record valid flag. No clearing pass.
// ----------------------------------------------------------------------------
// eth_ipv4_l4_header_parser
// Ethernet/IPv4/TCP-UDP header parser with HTTP request method detection.
// ----------------------------------------------------------------------------
`default_nettype none

module eth_ipv4_l4_header_parser #(
  parameter int unsigned HTTP_SCAN_LIMIT = ehp_pkg::HTTP_SCAN_LIMIT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  ehp_byte_if.sink  in_ch,
  ehp_rec_if.source out_ch
);
  import ehp_pkg::*;

  logic     push;
  q_entry_t push_data;
  logic     full;
  logic     pop;
  q_entry_t q_head;
  logic     q_valid;
  logic     snap_valid;
  snap_t    snap_data;
  logic     snap_ready;

  ehp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  ehp_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_data   (push_data),
    .full      (full),
    .pop       (pop),
    .rd_data   (q_head),
    .not_empty (q_valid)
  );

  ehp_back #(
    .HTTP_SCAN_LIMIT (HTTP_SCAN_LIMIT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .pop        (pop),
    .snap_valid (snap_valid),
    .snap_data  (snap_data),
    .snap_ready (snap_ready)
  );

  ehp_record u_record (
    .clk        (clk),
    .rst        (rst),
    .snap_valid (snap_valid),
    .snap_data  (snap_data),
    .snap_ready (snap_ready),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

/* tb/eth_ipv4_l4_header_parser_tb.sv */
// ----------------------------------------------------------------------------
// eth_ipv4_l4_header_parser_tb
// Feeds captured Ethernet frames byte by byte into the header parser and
// checks every parse record against a cycle-free predictor of the parser.
// Directed frames hit the size limits, rejected headers, short L4 headers,
// bad TCP offsets and each HTTP method. A few random frames follow.
// ----------------------------------------------------------------------------

module eth_ipv4_l4_header_parser_tb;
  import ehp_pkg::*;

  typedef logic [7:0] octet_t;

  typedef enum logic [2:0] {
    HTTP_NONE    = 3'd0,
    HTTP_GET     = 3'd1,
    HTTP_POST    = 3'd2,
    HTTP_HEAD    = 3'd3,
    HTTP_PUT     = 3'd4,
    HTTP_DELETE  = 3'd5,
    HTTP_OPTIONS = 3'd6,
    HTTP_PATCH   = 3'd7
  } http_method_t;

  typedef struct packed {
    logic         parsed;
    l4_kind_t     kind;
    logic [15:0]  total_len;
    logic [7:0]   ttl;
    logic [31:0]  src;
    logic [31:0]  dst;
    logic [15:0]  sport;
    logic [15:0]  dport;
    http_method_t method;
    logic [15:0]  cap;
    logic [15:0]  wlen;
  } flow_rec_t;

  localparam octet_t CR = 8'h0D;
  localparam octet_t LF = 8'h0A;

  class parse_scoreboard;
    int unsigned  scan_limit;
    logic [15:0]  nbytes, etype_r, tot_len_r, sport_r, dport_r;
    logic [7:0]   vihl_r, ttl_r, proto_r, tcp_off_r;
    logic [31:0]  src_r, dst_r;
    logic [6:0]   cand_r;
    http_method_t hit_r;
    logic [1:0]   spaces_r;
    logic         cr_r, eol_r, line_ok_r;
    flow_rec_t    pending[$];
    int           errors;
    int           checked;

    function new(int unsigned limit);
      scan_limit = limit;
      errors = 0;
      checked = 0;
      clear();
    endfunction

    function void clear();
      nbytes = '0;
      etype_r = '0;
      tot_len_r = '0;
      sport_r = '0;
      dport_r = '0;
      vihl_r = '0;
      ttl_r = '0;
      proto_r = '0;
      tcp_off_r = '0;
      src_r = '0;
      dst_r = '0;
      cand_r = '1;
      hit_r = HTTP_NONE;
      spaces_r = '0;
      cr_r = 1'b0;
      eol_r = 1'b0;
      line_ok_r = 1'b0;
    endfunction

    static function string word_of(http_method_t m);
      case (m)
        HTTP_GET:     return "GET ";
        HTTP_POST:    return "POST ";
        HTTP_HEAD:    return "HEAD ";
        HTTP_PUT:     return "PUT ";
        HTTP_DELETE:  return "DELETE ";
        HTTP_OPTIONS: return "OPTIONS ";
        HTTP_PATCH:   return "PATCH ";
        default:      return "";
      endcase
    endfunction

    // request line scan over the TCP payload
    function void scan(int unsigned idx, logic [7:0] b);
      string w;
      int    m;
      if (idx < 8) begin
        for (m = 1; m <= 7; m++) begin
          w = word_of(http_method_t'(m));
          if (idx < w.len()) begin
            if (b != w[idx]) cand_r[m-1] = 1'b0;
            else if (idx == w.len() - 1 && cand_r[m-1]) hit_r = http_method_t'(m);
          end
        end
      end
      if (!eol_r) begin
        if (b == LF && cr_r) begin
          eol_r = 1'b1;
          line_ok_r = (spaces_r >= 2);
        end else if (b == 8'h20 && spaces_r < 2) begin
          spaces_r++;
        end
        cr_r = (b == CR);
      end
    endfunction

    function void absorb(int unsigned pos, logic [7:0] b);
      int unsigned ihl, l4s, doff, r;
      if (pos == 12 || pos == 13) etype_r = {etype_r[7:0], b};
      if (pos == 14) vihl_r = b;
      if (pos == 16 || pos == 17) tot_len_r = {tot_len_r[7:0], b};
      if (pos == 22) ttl_r = b;
      if (pos == 23) proto_r = b;
      if (pos >= 26 && pos < 30) src_r = {src_r[23:0], b};
      if (pos >= 30 && pos < 34) dst_r = {dst_r[23:0], b};
      ihl = 4 * vihl_r[3:0];
      if (pos <= 14 || ihl < 20) return;
      l4s = 14 + ihl;
      if (pos >= l4s) begin
        r = pos - l4s;
        if (r < 2) sport_r = {sport_r[7:0], b};
        else if (r < 4) dport_r = {dport_r[7:0], b};
        else if (r == 12) tcp_off_r = b;
      end
      doff = 4 * tcp_off_r[7:4];
      if (doff >= 20 && proto_r == PROTO_TCP && pos >= l4s + doff &&
          pos - l4s - doff < scan_limit)
        scan(pos - l4s - doff, b);
    endfunction

    function void note_byte(logic [7:0] b, logic last, logic [15:0] wl);
      flow_rec_t   e;
      int unsigned cap, ihl, l4a, doff;
      e = '0;
      if (nbytes != 16'hFFFF) begin
        absorb(nbytes, b);
        nbytes++;
      end
      if (!last) return;
      cap = nbytes;
      ihl = 4 * vihl_r[3:0];
      if (!(cap < 14 || etype_r != ETH_TYPE_IPV4 || cap - 14 < 20 ||
            vihl_r[7:4] != IP_VERSION_4 || ihl < 20 || cap - 14 < ihl)) begin
        l4a = cap - 14 - ihl;
        e.parsed = 1'b1;
        e.total_len = tot_len_r;
        e.ttl = ttl_r;
        e.src = src_r;
        e.dst = dst_r;
        e.cap = nbytes;
        e.wlen = wl;
        if (proto_r == PROTO_TCP) begin
          if (l4a >= 20) begin
            e.kind = L4_TCP;
            e.sport = sport_r;
            e.dport = dport_r;
            doff = 4 * tcp_off_r[7:4];
            if (doff >= 20 && l4a >= doff && l4a - doff >= 16 && hit_r != HTTP_NONE &&
                eol_r && line_ok_r)
              e.method = hit_r;
          end
        end else if (proto_r == PROTO_UDP) begin
          if (l4a >= 8) begin
            e.kind = L4_UDP;
            e.sport = sport_r;
            e.dport = dport_r;
          end
        end else begin
          e.kind = L4_OTHER;
        end
      end
      pending.push_back(e);
      clear();
    endfunction

    task report(string msg);
      if (errors < 40) $display("MISMATCH %s", msg);
      errors++;
    endtask

    task cmp(string field, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("record %0d %s: got 0x%0h, expected 0x%0h",
                         checked, field, got, want));
    endtask

    task check_record(flow_rec_t got);
      flow_rec_t want;
      if (pending.size() == 0) begin
        report($sformatf("record with no frame pending (parsed %0d, cap_len %0d)",
                         got.parsed, got.cap));
        return;
      end
      want = pending.pop_front();
      checked++;
      cmp("parsed", got.parsed, want.parsed);
      cmp("l4_kind", got.kind, want.kind);
      cmp("ip_len", got.total_len, want.total_len);
      cmp("ip_ttl", got.ttl, want.ttl);
      cmp("src_addr", got.src, want.src);
      cmp("dst_addr", got.dst, want.dst);
      cmp("l4_sport", got.sport, want.sport);
      cmp("l4_dport", got.dport, want.dport);
      cmp("req_method", got.method, want.method);
      cmp("cap_len", got.cap, want.cap);
      cmp("frame_wire_len", got.wlen, want.wlen);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;

  ehp_byte_if in_ch();
  ehp_rec_if  out_ch();

  eth_ipv4_l4_header_parser uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk = ~clk;

  parse_scoreboard sb;
  octet_t          frame_q[$];
  octet_t          body_q[$];
  flow_rec_t       seen_rec;
  int              send_idle_pct;
  int              recv_idle_pct;
  int              bytes_sent = 0;
  int              frames_sent = 0;

  // receiver side
  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      seen_rec.parsed = out_ch.parsed;
      seen_rec.kind = l4_kind_t'(out_ch.l4_kind);
      seen_rec.total_len = out_ch.ip_len;
      seen_rec.ttl = out_ch.ip_ttl;
      seen_rec.src = out_ch.src_addr;
      seen_rec.dst = out_ch.dst_addr;
      seen_rec.sport = out_ch.l4_sport;
      seen_rec.dport = out_ch.l4_dport;
      seen_rec.method = http_method_t'(out_ch.req_method);
      seen_rec.cap = out_ch.cap_len;
      seen_rec.wlen = out_ch.frame_wire_len;
      sb.check_record(seen_rec);
    end
  end

  task automatic send_byte(octet_t b, logic last, logic [15:0] wl);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.frame_byte = b;
    in_ch.last_byte = last;
    in_ch.wire_len = wl;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_byte(b, last, wl);
    bytes_sent++;
  endtask

  task automatic send_frame(logic [15:0] wl);
    int i;
    int n;
    n = frame_q.size();
    for (i = 0; i < n; i++)
      send_byte(frame_q[i], i == n - 1, (i == n - 1) ? wl : 16'($urandom));
    frames_sent++;
  endtask

  function automatic octet_t rnd8();
    return octet_t'($urandom);
  endfunction

  task automatic push16(logic [15:0] v);
    frame_q.push_back(v[15:8]);
    frame_q.push_back(v[7:0]);
  endtask

  task automatic put_random(int n);
    repeat (n) body_q.push_back(rnd8());
  endtask

  task automatic put_letters(int n);
    repeat (n) body_q.push_back(octet_t'(8'h61 + $urandom_range(0, 25)));
  endtask

  task automatic put_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) body_q.push_back(s[i]);
  endtask

  task automatic put_crlf();
    body_q.push_back(CR);
    body_q.push_back(LF);
  endtask

  task automatic put_request(http_method_t m, int path_len);
    put_text(parse_scoreboard::word_of(m));
    put_text("/");
    put_letters(path_len);
    put_text(" HTTP/1.1");
    put_crlf();
  endtask

  // Ethernet + IPv4 (+ options) + TCP/UDP header, then body_q
  task automatic build_frame(logic [15:0] etype, octet_t vihl, octet_t proto, octet_t tcp_off);
    frame_q = {};
    repeat (12) frame_q.push_back(rnd8());
    push16(etype);
    frame_q.push_back(vihl);
    frame_q.push_back(rnd8());
    push16(16'($urandom));
    repeat (4) frame_q.push_back(rnd8());
    frame_q.push_back(rnd8());
    frame_q.push_back(proto);
    repeat (10) frame_q.push_back(rnd8());
    if (vihl[3:0] > 5) repeat (4 * (vihl[3:0] - 5)) frame_q.push_back(rnd8());
    if (proto == PROTO_TCP) begin
      repeat (12) frame_q.push_back(rnd8());
      frame_q.push_back(tcp_off);
      repeat (7) frame_q.push_back(rnd8());
      if (tcp_off[7:4] > 5) repeat (4 * (tcp_off[7:4] - 5)) frame_q.push_back(rnd8());
    end else if (proto == PROTO_UDP) begin
      repeat (8) frame_q.push_back(rnd8());
    end
    foreach (body_q[i]) frame_q.push_back(body_q[i]);
  endtask

  task automatic cut_to(int n);
    if (frame_q.size() > n) frame_q = frame_q[0:n-1];
  endtask

  task automatic run_directed();
    int cuts[4] = '{1, 13, 14, 33};
    int k;
    body_q = {};
    for (k = 0; k < 4; k++) begin
      build_frame(ETH_TYPE_IPV4, 8'h45, 8'h01, 8'h50);
      cut_to(cuts[k]);
      send_frame((k == 0) ? 16'h0000 : 16'hFFFF);
    end
    build_frame(ETH_TYPE_IPV4, 8'h45, 8'h01, 8'h50);
    send_frame(16'd34);

    // header rejects; then max IHL, cut inside options and complete
    body_q = {};
    put_request(HTTP_GET, 3);
    build_frame(16'h86DD, 8'h45, PROTO_TCP, 8'h50);
    send_frame(16'($urandom));
    build_frame(ETH_TYPE_IPV4, 8'h65, PROTO_TCP, 8'h50);
    send_frame(16'($urandom));
    build_frame(ETH_TYPE_IPV4, 8'h44, PROTO_TCP, 8'h50);
    send_frame(16'($urandom));
    build_frame(ETH_TYPE_IPV4, 8'h4F, PROTO_UDP, 8'h50);
    cut_to(14 + 59);
    send_frame(16'($urandom));
    build_frame(ETH_TYPE_IPV4, 8'h4F, PROTO_UDP, 8'h50);
    send_frame(16'($urandom));

    // L4 header one byte short
    build_frame(ETH_TYPE_IPV4, 8'h45, PROTO_TCP, 8'h50);
    cut_to(14 + 20 + 19);
    send_frame(16'($urandom));
    build_frame(ETH_TYPE_IPV4, 8'h45, PROTO_UDP, 8'h50);
    cut_to(14 + 20 + 7);
    send_frame(16'($urandom));

    // data offset below minimum, past capture, and at maximum
    build_frame(ETH_TYPE_IPV4, 8'h45, PROTO_TCP, 8'h40);
    send_frame(16'($urandom));
    build_frame(ETH_TYPE_IPV4, 8'h45, PROTO_TCP, 8'hF0);
    cut_to(14 + 20 + 50);
    send_frame(16'($urandom));
    build_frame(ETH_TYPE_IPV4, 8'h45, PROTO_TCP, 8'hF0);
    send_frame(16'($urandom));

    for (k = 1; k <= 7; k++) begin
      body_q = {};
      put_request(http_method_t'(k), k - 1);
      build_frame(ETH_TYPE_IPV4, 8'h45, PROTO_TCP, 8'h50);
      send_frame(16'($urandom));
    end

    // payload of 15 then 16 bytes
    body_q = {};
    put_text("GET / HTTP/1");
    put_crlf();
    put_text("x");
    build_frame(ETH_TYPE_IPV4, 8'h45, PROTO_TCP, 8'h50);
    send_frame(16'($urandom));
    put_text("x");
    build_frame(ETH_TYPE_IPV4, 8'h45, PROTO_TCP, 8'h50);
    send_frame(16'($urandom));

    // one space only, lower case, CR alone, LF alone, word without its space
    body_q = {};
    put_text("POST /form");
    put_crlf();
    put_letters(10);
    build_frame(ETH_TYPE_IPV4, 8'h45, PROTO_TCP, 8'h50);
    send_frame(16'($urandom));
    body_q = {};
    put_text("get / HTTP/1.1");
    put_crlf();
    build_frame(ETH_TYPE_IPV4, 8'h45, PROTO_TCP, 8'h50);
    send_frame(16'($urandom));
    body_q = {};
    put_text("HEAD / HTTP/1.1");
    body_q.push_back(CR);
    put_letters(10);
    build_frame(ETH_TYPE_IPV4, 8'h45, PROTO_TCP, 8'h50);
    send_frame(16'($urandom));
    body_q = {};
    put_text("PUT / HTTP/1.1");
    body_q.push_back(LF);
    put_letters(10);
    build_frame(ETH_TYPE_IPV4, 8'h45, PROTO_TCP, 8'h50);
    send_frame(16'($urandom));
    body_q = {};
    put_text("PUTS / HTTP/1.1");
    put_crlf();
    build_frame(ETH_TYPE_IPV4, 8'h45, PROTO_TCP, 8'h50);
    send_frame(16'($urandom));
  endtask

  task automatic random_frame();
    int           pick;
    int           n;
    http_method_t m;
    string        w;
    octet_t       vihl, tcp_off, proto;
    logic [15:0]  etype;
    body_q = {};
    pick = $urandom_range(0, 99);
    etype = ETH_TYPE_IPV4;
    vihl = ($urandom_range(0, 9) == 0) ? {4'h4, 4'($urandom_range(6, 15))} : 8'h45;
    tcp_off = {4'h5, 4'($urandom)};
    proto = PROTO_TCP;
    if (pick < 45) begin
      m = http_method_t'($urandom_range(1, 7));
      w = parse_scoreboard::word_of(m);
      case ($urandom_range(0, 9))
        5: begin
          put_request(m, $urandom_range(0, 6));
          n = $urandom_range(0, w.len() - 1);
          body_q[n] = body_q[n] ^ (8'h01 << $urandom_range(0, 7));
        end
        6: begin
          put_text(w);
          put_text("/page");
          put_crlf();
          put_letters(12);
        end
        7: begin
          put_text(w);
          put_text("/ ");
          put_letters($urandom_range(0, 20));
        end
        8: begin
          put_text(w);
          put_text("/ H");
          put_crlf();
          put_letters($urandom_range(0, 6));
        end
        9: begin
          put_text(w.substr(0, 1));
          put_random($urandom_range(0, 24));
        end
        default: begin
          put_request(m, $urandom_range(0, 6));
          put_letters($urandom_range(0, 8));
        end
      endcase
      if ($urandom_range(0, 5) == 0) tcp_off = {4'($urandom), 4'($urandom)};
      else if ($urandom_range(0, 4) == 0) tcp_off = {4'($urandom_range(6, 9)), 4'($urandom)};
    end else if (pick < 60) begin
      put_random($urandom_range(0, 20));
      tcp_off = {4'($urandom_range(5, 8)), 4'($urandom)};
    end else if (pick < 75) begin
      proto = PROTO_UDP;
      put_random($urandom_range(0, 12));
    end else if (pick < 85) begin
      proto = rnd8();
      put_random($urandom_range(0, 10));
    end else begin
      put_random($urandom_range(0, 8));
      case ($urandom_range(0, 3))
        0: etype = 16'($urandom);
        1: vihl = {4'($urandom), 4'h5};
        2: vihl = {4'h4, 4'($urandom_range(0, 4))};
        default: ;
      endcase
    end
    build_frame(etype, vihl, proto, tcp_off);
    if (pick >= 85 || $urandom_range(0, 9) == 0) cut_to($urandom_range(1, frame_q.size()));
    send_frame(($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom));
  endtask

  task automatic random_phase(int budget);
    int b0;
    b0 = bytes_sent;
    while (bytes_sent - b0 < budget) random_frame();
  endtask

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.frame_byte = '0;
    in_ch.last_byte = 1'b0;
    in_ch.wire_len = '0;
    out_ch.ready = 1'b0;
    sb = new(HTTP_SCAN_LIMIT_DEF);
    send_idle_pct = 14;
    recv_idle_pct = 65;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_directed();
    send_idle_pct = 65;
    recv_idle_pct = 14;
    random_phase(30);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(30);

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d frames (%0d bytes); checked %0d parse records, %0d mismatches.",
             frames_sent, bytes_sent, sb.checked, sb.errors);
    $display("Frames covered runts, header rejects, short L4, offsets and all methods.");
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("Timeout: parser stopped making progress");
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* files.f */
src/ehp_pkg.sv
src/ehp_byte_if.sv
src/ehp_rec_if.sv
src/ehp_front.sv
src/ehp_fifo.sv
src/ehp_back.sv
src/ehp_record.sv
src/eth_ipv4_l4_header_parser.sv
tb/eth_ipv4_l4_header_parser_tb.sv
